[hdl/jacobi_poisson_periodic_sweep_unit_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef JACOBI_POISSON_PERIODIC_SWEEP_UNIT_ASSERT_SVH
`define JACOBI_POISSON_PERIODIC_SWEEP_UNIT_ASSERT_SVH

// Same-cycle implication, skipped while the disable condition is high.
`define JPPS_ASSERT_IMPLY(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("jpps assertion failed");

// Next-cycle implication, skipped while the disable condition is high.
`define JPPS_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("jpps assertion failed");

`endif

[hdl/jpps_pkg.sv]
`default_nettype none
package jpps_pkg;

   // Fixed field widths of the stream payloads.
   localparam int COORD_W    = 6;
   localparam int CFG_DIM_W  = 7;
   localparam int WORD_W     = 32;
   localparam int COORD_LIMIT = 64;

   // Request tdata: row, col, pressure_in, source_in (76 bits, padded to 80).
   localparam int REQ_ROW_LSB  = 0;
   localparam int REQ_COL_LSB  = REQ_ROW_LSB + COORD_W;
   localparam int REQ_PRES_LSB = REQ_COL_LSB + COORD_W;
   localparam int REQ_SRC_LSB  = REQ_PRES_LSB + WORD_W;
   localparam int REQ_USED_W   = REQ_SRC_LSB + WORD_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = WORD_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_SCALE = 2'd2;

   localparam logic [CFG_DIM_W-1:0] ROWS_RESET  = 7'd64;
   localparam logic [CFG_DIM_W-1:0] COLS_RESET  = 7'd64;
   localparam logic [WORD_W-1:0]    SCALE_RESET = 32'h0001_0000;

   // Operation codes carried on req_tuser.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   // Response status codes carried on rsp_tuser.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_OUT_RANGE = 1'b1;

   // Arithmetic widths: product Q32.32, term Q32.16, accumulator with headroom.
   localparam int PROD_W = 2 * WORD_W;
   localparam int TERM_W = PROD_W - 16;
   localparam int ACC_W  = TERM_W + 2;

   typedef enum logic [1:0] {
      SEL_REQ   = 2'd0,
      SEL_DOWN  = 2'd1,
      SEL_LEFT  = 2'd2,
      SEL_RIGHT = 2'd3
   } addr_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD     = 2'd0,
      ACC_LOAD     = 2'd1,
      ACC_ADD_TERM = 2'd2,
      ACC_ADD      = 2'd3
   } acc_op_type;

   typedef struct packed {
      logic         capture;
      logic         mem_write;
      addr_sel_type addr_sel;
      acc_op_type   acc_op;
      logic         out_write;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_compute;
      logic out_busy;
   } status_type;

endpackage
`default_nettype wire

[hdl/jpps_ctrl.sv]
`default_nettype none
module jpps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  jpps_pkg::status_type sts,
   output jpps_pkg::cmd_type    cmd
);
   import jpps_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DOWN   = 6'b000010,
      ST_LEFT   = 6'b000100,
      ST_RIGHT  = 6'b001000,
      ST_LAST   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.capture   = 1'b0;
      cmd.mem_write = 1'b0;
      cmd.addr_sel  = SEL_REQ;
      cmd.acc_op    = ACC_HOLD;
      cmd.out_write = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (!sts.in_range) begin
                  state_in = ST_FINISH;
               end else if (sts.is_compute) begin
                  state_in = ST_DOWN;
               end else begin
                  cmd.mem_write = 1'b1;
               end
            end
         end
         // The pressure read issued at accept returns here; ST_DOWN, ST_LEFT and
         // ST_RIGHT issue the next neighbor address and fold in the word just returned.
         ST_DOWN: begin
            cmd.addr_sel = SEL_DOWN;
            cmd.acc_op   = ACC_LOAD;
            state_in     = ST_LEFT;
         end
         ST_LEFT: begin
            cmd.addr_sel = SEL_LEFT;
            cmd.acc_op   = ACC_ADD_TERM;
            state_in     = ST_RIGHT;
         end
         ST_RIGHT: begin
            cmd.addr_sel = SEL_RIGHT;
            cmd.acc_op   = ACC_ADD;
            state_in     = ST_LAST;
         end
         ST_LAST: begin
            cmd.addr_sel = SEL_RIGHT;
            cmd.acc_op   = ACC_ADD;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.out_busy) begin
               cmd.out_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[hdl/jpps_datapath.sv]
`default_nettype none
module jpps_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [jpps_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [jpps_pkg::WORD_W-1:0]           csr_wdata,
   input  logic [jpps_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tuser,
   input  jpps_pkg::cmd_type                     cmd,
   output jpps_pkg::status_type                  sts,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [jpps_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser
);
   import jpps_pkg::*;

   localparam int EFF_ROWS = (MAX_ROWS < COORD_LIMIT) ? MAX_ROWS : COORD_LIMIT;
   localparam int EFF_COLS = (MAX_COLS < COORD_LIMIT) ? MAX_COLS : COORD_LIMIT;
   localparam int ROW_AW   = $clog2(EFF_ROWS);
   localparam int COL_AW   = $clog2(EFF_COLS);
   localparam int AW       = ROW_AW + COL_AW;
   localparam int DEPTH    = 1 << AW;
   localparam logic [CFG_DIM_W-1:0] ROW_CAP = CFG_DIM_W'(EFF_ROWS);
   localparam logic [CFG_DIM_W-1:0] COL_CAP = CFG_DIM_W'(EFF_COLS);

   // Configuration registers.
   logic [CFG_DIM_W-1:0] rows_ff, rows_in;
   logic [CFG_DIM_W-1:0] cols_ff, cols_in;
   logic [WORD_W-1:0]    scale_ff, scale_in;

   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      scale_in = scale_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS_IN_USE:  rows_in  = csr_wdata[CFG_DIM_W-1:0];
            CSR_COLS_IN_USE:  cols_in  = csr_wdata[CFG_DIM_W-1:0];
            CSR_SOURCE_SCALE: scale_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_RESET;
         cols_ff  <= COLS_RESET;
         scale_ff <= SCALE_RESET;
      end else begin
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         scale_ff <= scale_in;
      end
   end

   // Request fields and neighbor coordinates with wrap-around.
   logic [COORD_W-1:0]   req_row, req_col;
   logic [WORD_W-1:0]    req_pres, req_src;
   logic [CFG_DIM_W-1:0] nr, nc, row_x, col_x, row_p1, col_p1;
   logic [COORD_W-1:0]   up_row, down_row, left_col, right_col;

   assign req_row  = req_tdata[REQ_ROW_LSB +: COORD_W];
   assign req_col  = req_tdata[REQ_COL_LSB +: COORD_W];
   assign req_pres = req_tdata[REQ_PRES_LSB +: WORD_W];
   assign req_src  = req_tdata[REQ_SRC_LSB +: WORD_W];

   assign nr     = (rows_ff > ROW_CAP) ? ROW_CAP : rows_ff;
   assign nc     = (cols_ff > COL_CAP) ? COL_CAP : cols_ff;
   assign row_x  = {1'b0, req_row};
   assign col_x  = {1'b0, req_col};
   assign row_p1 = row_x + 7'd1;
   assign col_p1 = col_x + 7'd1;

   assign up_row    = (req_row == '0) ? COORD_W'(nr - 7'd1) : req_row - 6'd1;
   assign down_row  = (row_p1 >= nr) ? '0 : row_p1[COORD_W-1:0];
   assign left_col  = (req_col == '0) ? COORD_W'(nc - 7'd1) : req_col - 6'd1;
   assign right_col = (col_p1 >= nc) ? '0 : col_p1[COORD_W-1:0];

   assign sts.in_range   = (row_x < nr) && (col_x < nc);
   assign sts.is_compute = (req_tuser == OP_COMPUTE);
   assign sts.out_busy   = rsp_tvalid && !rsp_tready;

   // Captured item.
   logic [AW-1:0] home_ff, home_in;
   logic [AW-1:0] down_ff, down_in;
   logic [AW-1:0] left_ff, left_in;
   logic [AW-1:0] right_ff, right_in;
   logic          err_ff, err_in;
   logic [AW-1:0] req_home, req_up;

   assign req_home = {req_row[ROW_AW-1:0], req_col[COL_AW-1:0]};
   assign req_up   = {up_row[ROW_AW-1:0], req_col[COL_AW-1:0]};

   always_comb begin
      home_in  = home_ff;
      down_in  = down_ff;
      left_in  = left_ff;
      right_in = right_ff;
      err_in   = err_ff;
      if (cmd.capture) begin
         home_in  = req_home;
         down_in  = {down_row[ROW_AW-1:0], req_col[COL_AW-1:0]};
         left_in  = {req_row[ROW_AW-1:0], left_col[COL_AW-1:0]};
         right_in = {req_row[ROW_AW-1:0], right_col[COL_AW-1:0]};
         err_in   = !sts.in_range;
      end
   end

   always_ff @(posedge clock) begin
      home_ff  <= home_in;
      down_ff  <= down_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      err_ff   <= err_in;
   end

   // Single-port grid stores with registered read data.
   logic [WORD_W-1:0] p_mem [DEPTH];
   logic [WORD_W-1:0] s_mem [DEPTH];
   logic [WORD_W-1:0] p_rdata_ff, s_rdata_ff;
   logic [AW-1:0]     p_addr, s_addr;

   always_comb begin
      case (cmd.addr_sel)
         SEL_REQ:   p_addr = (req_tuser == OP_COMPUTE) ? req_up : req_home;
         SEL_DOWN:  p_addr = down_ff;
         SEL_LEFT:  p_addr = left_ff;
         SEL_RIGHT: p_addr = right_ff;
         default:   p_addr = home_ff;
      endcase
   end

   assign s_addr = (cmd.addr_sel == SEL_REQ) ? req_home : home_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         p_mem[p_addr] <= req_pres;
      end
      p_rdata_ff <= p_mem[p_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         s_mem[s_addr] <= req_src;
      end
      s_rdata_ff <= s_mem[s_addr];
   end

   // Accumulator: four neighbors plus the source term, exact.
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  p_ext, term_ext;

   assign p_ext    = {{(ACC_W-WORD_W){p_rdata_ff[WORD_W-1]}}, p_rdata_ff};
   // Dropping the low 16 product bits is a floor for both signs.
   assign term_ext = {{(ACC_W-TERM_W){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:16]};

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      case (cmd.acc_op)
         ACC_LOAD: begin
            prod_in = $signed(scale_ff) * $signed(s_rdata_ff);
            acc_in  = p_ext;
         end
         ACC_ADD_TERM: acc_in = acc_ff + p_ext + term_ext;
         ACC_ADD:      acc_in = acc_ff + p_ext;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Quarter with floor, then saturate to 32 bits.
   logic [ACC_W-3:0]  quarter;
   logic [WORD_W-1:0] sat_value;

   assign quarter = acc_ff[ACC_W-1:2];

   always_comb begin
      if ((&quarter[ACC_W-3:WORD_W-1]) || !(|quarter[ACC_W-3:WORD_W-1])) begin
         sat_value = quarter[WORD_W-1:0];
      end else if (quarter[ACC_W-3]) begin
         sat_value = 32'h8000_0000;
      end else begin
         sat_value = 32'h7FFF_FFFF;
      end
   end

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.out_write) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = err_ff ? '0 : sat_value;
         rsp_user_in  = err_ff ? STATUS_OUT_RANGE : STATUS_OK;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

[hdl/jacobi_poisson_periodic_sweep_unit.sv]
// Channel   Dir  Handshake            Payload
// req       in   req_tvalid/tready    tuser: operation; tdata: row, col, pressure_in, source_in
// rsp       out  rsp_tvalid/tready    tuser: status; tdata: new_value
// csr       in   csr_we               csr_index, csr_wdata
//
// A load writes both stores on acceptance and the next request may follow directly.
// A compute runs ST_DOWN, ST_LEFT, ST_RIGHT, ST_LAST and ST_FINISH: four pressure reads
// through the single-port pressure store, overlapped with the source read and the multiply,
// then the final quarter and saturation. An out-of-range request skips to ST_FINISH.
// Reset is synchronous and active high; it sets state, CSRs and rsp_tvalid to defaults.
// A stalled response holds the block in its last state until rsp_tready.
`default_nettype none
module jacobi_poisson_periodic_sweep_unit #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [jpps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [jpps_pkg::WORD_W-1:0]         csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row [5:0], col [11:6], pressure_in [43:12], source_in [75:44], zero pad
   input  logic [jpps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // new_value [31:0]
   output logic [jpps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status [0]
   output logic                                rsp_tuser
);
   import jpps_pkg::*;

   cmd_type    cmd;
   status_type sts;

   jpps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   jpps_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

[hdl/jpps_checker.sv]
`default_nettype none
`include "jacobi_poisson_periodic_sweep_unit_assert.svh"
module jpps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [jpps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                rsp_tuser
);
   import jpps_pkg::*;

   // A stalled response keeps its payload.
   `JPPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // An error response always carries a zero value.
   `JPPS_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_tvalid && (rsp_tuser == STATUS_OUT_RANGE), rsp_tdata == '0)
   // Any accepted compute request takes the block out of ready, so it is busy afterwards.
   `JPPS_ASSERT_NEXT(a_compute_busy, clock, reset, req_tvalid && req_tready && (req_tuser == OP_COMPUTE), !req_tready)
   // Coming out of reset the block is idle with no response pending.
   `JPPS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_tready && !rsp_tvalid)

endmodule

bind jacobi_poisson_periodic_sweep_unit jpps_checker u_jpps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
